[sv/rcpr_pkg.sv]
// Shared types and constants for the row/column permutation remap block.
package rcpr_pkg;

  localparam int MAX_ROWS = 2048;
  localparam int MAX_COLS = 8192;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int COL_AW   = $clog2(MAX_COLS);

  localparam int CMD_W    = 2;
  localparam int IDX_W    = 14;
  localparam int CELL_W   = 25;
  localparam int RLEN_W   = 14;
  localparam int RCNT_W   = 12;
  localparam int ROWO_W   = 12;
  localparam int COLO_W   = 14;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 14;

  localparam int DIV_STEPS = CELL_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam logic [RLEN_W-1:0] ROW_LENGTH_RST = RLEN_W'(5678);
  localparam logic [RCNT_W-1:0] ROW_COUNT_RST  = RCNT_W'(1234);

  localparam logic [CMD_W-1:0] CMD_SWAP_ROWS = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SWAP_COLS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_VALUE     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOCATE    = 2'd3;

  localparam logic [CFG_IW-1:0] CFG_ROW_LENGTH = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ROW_COUNT  = 2'd1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  second_index;
    logic [CELL_W-1:0] cell_number;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] value_out;
    logic [ROWO_W-1:0] row_out;
    logic [COLO_W-1:0] col_out;
    logic              range_error;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [CELL_W-1:0] dividend;
    logic [RLEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CELL_W-1:0] quotient;
    logic [RLEN_W-1:0] remainder;
  } div_rsp_t;

endpackage

[sv/rcpr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rcpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/rcpr_div.sv]
// Iterative restoring divider: one quotient bit per cycle.
module rcpr_div
  import rcpr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [DIV_CW-1:0] cnt;
  logic [RLEN_W-1:0] rem;
  logic [CELL_W-1:0] qd;
  logic [RLEN_W-1:0] dvs;

  logic [RLEN_W:0]   trial;
  logic [RLEN_W+1:0] diff;
  logic              ge;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem, qd[CELL_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};
  assign ge    = ~diff[RLEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CW'(1);
        if (cnt == DIV_CW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      qd  <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[RLEN_W-1:0] : trial[RLEN_W-1:0];
      qd  <= {qd[CELL_W-2:0], ge};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = qd;
  assign rsp.remainder = rem;

endmodule

[sv/row_col_permutation_remap_top.sv]
// Row/column permutation remap: top level with sequencer, tables, divider and output register.
//
// Usage: items enter on in_valid/in_ready/in_data and results leave on
// out_valid/out_ready/out_data. Swap items (rows or columns) update both the
// forward table and its inverse and give no result. Value queries return the
// cell number now shown at a row/column position; locate queries return the
// current row and column positions of a cell number. Registers row_length and
// row_count are written on cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high, and writes are expected only while the block is idle.
// One item is worked on at a time and in_ready is low meanwhile. A swap reads
// both entries (S_DECODE, S_RD_B) and writes them back (S_WR1, S_WR2) before
// the next item is accepted. A value query reads the tables, multiplies and
// adds (S_MUL, S_SUM) before its result is shown. A locate query runs the
// divider, one quotient bit per cycle over 25 bits, then one read of the
// inverse tables. After reset, a clearing pass over all 8192 column addresses
// writes the identity into all tables, and no item is accepted until it ends.
// A result waits in the output register while out_ready is low; the next item
// is still accepted; it stalls only when its own result needs that register.
module row_col_permutation_remap_top
  import rcpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_RD_B   = 4'd3;
  localparam logic [3:0] S_WR1    = 4'd4;
  localparam logic [3:0] S_WR2    = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_SUM    = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_LOC    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [COL_AW-1:0] clr_cnt;

  logic [RLEN_W-1:0] row_length;
  logic [RCNT_W-1:0] row_count;

  in_item_t          item;
  out_item_t         res;
  logic [COL_AW-1:0] ea;
  logic [COL_AW-1:0] eb;
  logic [CELL_W-1:0] prod;
  logic [COL_AW-1:0] csave;

  // Table ports.
  logic              ra_we, rp_we, ca_we, cp_we;
  logic              ra_re, rp_re, ca_re, cp_re;
  logic [ROW_AW-1:0] ra_waddr, rp_waddr, ra_raddr, rp_raddr;
  logic [ROW_AW-1:0] ra_wdata, rp_wdata, ra_rdata, rp_rdata;
  logic [COL_AW-1:0] ca_waddr, cp_waddr, ca_raddr, cp_raddr;
  logic [COL_AW-1:0] ca_wdata, cp_wdata, ca_rdata, cp_rdata;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [RCNT_W-1:0] nr;
  logic [RLEN_W-1:0] nc;
  logic              a_row_ok, b_row_ok, a_col_ok, b_col_ok;
  logic              sel_col;
  logic [COL_AW-1:0] a_m1, b_m1;
  logic [COL_AW-1:0] rd_at;
  logic              loc_ok;
  logic              out_free;

  // Valid spans: rows 1..min(row_count, MAX_ROWS), columns 1..min(row_length, MAX_COLS).
  assign nr = (row_count > RCNT_W'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS) : row_count;
  assign nc = (row_length > RLEN_W'(MAX_COLS)) ? RLEN_W'(MAX_COLS) : row_length;

  assign a_row_ok = (item.first_index != '0) &&
                    (item.first_index <= IDX_W'(nr));
  assign b_row_ok = (item.second_index != '0) &&
                    (item.second_index <= IDX_W'(nr));
  assign a_col_ok = (item.first_index != '0) && (item.first_index <= nc);
  assign b_col_ok = (item.second_index != '0) && (item.second_index <= nc);

  assign sel_col = (item.command == CMD_SWAP_COLS);
  assign a_m1    = COL_AW'(item.first_index - IDX_W'(1));
  assign b_m1    = COL_AW'(item.second_index - IDX_W'(1));
  assign rd_at   = sel_col ? ca_rdata : COL_AW'(ra_rdata);

  // The quotient is the original row minus one and the remainder the column minus one.
  assign loc_ok = (div_rsp.quotient < CELL_W'(nr)) && (div_rsp.remainder < nc);

  assign out_free  = ~out_valid | out_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LENGTH_RST;
      row_count  <= ROW_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW_LENGTH: row_length <= cfg_data;
        CFG_ROW_COUNT:  row_count  <= RCNT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_cnt == '1) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (item.command)
          CMD_SWAP_ROWS: state_next = (a_row_ok && b_row_ok) ? S_RD_B : S_IDLE;
          CMD_SWAP_COLS: state_next = (a_col_ok && b_col_ok) ? S_RD_B : S_IDLE;
          CMD_VALUE:     state_next = (a_row_ok && b_col_ok) ? S_MUL : S_OUT;
          CMD_LOCATE: begin
            if (item.cell_number == '0 || row_length == '0) begin
              state_next = S_OUT;
            end else begin
              state_next = S_DIV;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_RD_B:   state_next = S_WR1;
      S_WR1:    state_next = S_WR2;
      S_WR2:    state_next = S_IDLE;
      S_MUL:    state_next = S_SUM;
      S_SUM:    state_next = S_OUT;
      S_DIV:    if (div_rsp.done) state_next = loc_ok ? S_LOC : S_OUT;
      S_LOC:    state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + COL_AW'(1);
      end
    end
  end

  // Table port control.
  always_comb begin
    ra_we = 1'b0; rp_we = 1'b0; ca_we = 1'b0; cp_we = 1'b0;
    ra_re = 1'b0; rp_re = 1'b0; ca_re = 1'b0; cp_re = 1'b0;
    ra_waddr = '0; ra_wdata = '0; rp_waddr = '0; rp_wdata = '0;
    ca_waddr = '0; ca_wdata = '0; cp_waddr = '0; cp_wdata = '0;
    ra_raddr = ROW_AW'(a_m1);
    ca_raddr = a_m1;
    rp_raddr = ROW_AW'(div_rsp.quotient);
    cp_raddr = COL_AW'(div_rsp.remainder);
    div_req.start    = 1'b0;
    div_req.dividend = item.cell_number - CELL_W'(1);
    div_req.divisor  = row_length;
    unique case (state)
      S_CLEAR: begin
        // Identity fill; the row tables take only the lower part of the sweep.
        ca_we = 1'b1; ca_waddr = clr_cnt; ca_wdata = clr_cnt;
        cp_we = 1'b1; cp_waddr = clr_cnt; cp_wdata = clr_cnt;
        ra_we = (clr_cnt < COL_AW'(MAX_ROWS));
        rp_we = ra_we;
        ra_waddr = ROW_AW'(clr_cnt); ra_wdata = ROW_AW'(clr_cnt);
        rp_waddr = ROW_AW'(clr_cnt); rp_wdata = ROW_AW'(clr_cnt);
      end
      S_DECODE: begin
        unique case (item.command)
          CMD_SWAP_ROWS: ra_re = 1'b1;
          CMD_SWAP_COLS: ca_re = 1'b1;
          CMD_VALUE: begin
            ra_re    = 1'b1;
            ca_re    = 1'b1;
            ca_raddr = b_m1;
          end
          CMD_LOCATE: div_req.start = (item.cell_number != '0) && (row_length != '0);
          default: ;
        endcase
      end
      S_RD_B: begin
        ra_re    = ~sel_col;
        ca_re    = sel_col;
        ra_raddr = ROW_AW'(b_m1);
        ca_raddr = b_m1;
      end
      S_WR1: begin
        // at[a] takes eb, pos[ea] takes b.
        ra_we = ~sel_col; ra_waddr = ROW_AW'(a_m1); ra_wdata = ROW_AW'(rd_at);
        rp_we = ~sel_col; rp_waddr = ROW_AW'(ea);   rp_wdata = ROW_AW'(b_m1);
        ca_we = sel_col;  ca_waddr = a_m1;          ca_wdata = rd_at;
        cp_we = sel_col;  cp_waddr = ea;            cp_wdata = b_m1;
      end
      S_WR2: begin
        // at[b] takes ea, pos[eb] takes a; last, so equal indices end right.
        ra_we = ~sel_col; ra_waddr = ROW_AW'(b_m1); ra_wdata = ROW_AW'(ea);
        rp_we = ~sel_col; rp_waddr = ROW_AW'(eb);   rp_wdata = ROW_AW'(a_m1);
        ca_we = sel_col;  ca_waddr = b_m1;          ca_wdata = ea;
        cp_we = sel_col;  cp_waddr = eb;            cp_wdata = a_m1;
      end
      S_DIV: begin
        rp_re = div_rsp.done & loc_ok;
        cp_re = div_rsp.done & loc_ok;
      end
      default: ;
    endcase
  end

  // Item capture, swap temporaries and result assembly.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item <= in_data;
    end
    if (state == S_RD_B) begin
      ea <= rd_at;
    end
    if (state == S_WR1) begin
      eb <= rd_at;
    end
    if (state == S_MUL) begin
      prod  <= CELL_W'(row_length) * CELL_W'(ra_rdata);
      csave <= ca_rdata;
    end
    unique case (state)
      S_DECODE: res <= '{value_out: '0, row_out: '0, col_out: '0, range_error: 1'b1};
      S_SUM: begin
        res.value_out   <= prod + CELL_W'(csave) + CELL_W'(1);
        res.range_error <= 1'b0;
      end
      S_LOC: begin
        res.row_out     <= ROWO_W'(rp_rdata) + ROWO_W'(1);
        res.col_out     <= COLO_W'(cp_rdata) + COLO_W'(1);
        res.range_error <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_data <= res;
    end
  end

  rcpr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  rcpr_ram #(.WIDTH(ROW_AW), .DEPTH(MAX_ROWS)) u_row_at (
    .clk (clk), .we (ra_we), .waddr (ra_waddr), .wdata (ra_wdata),
    .re (ra_re), .raddr (ra_raddr), .rdata (ra_rdata)
  );

  rcpr_ram #(.WIDTH(ROW_AW), .DEPTH(MAX_ROWS)) u_row_pos (
    .clk (clk), .we (rp_we), .waddr (rp_waddr), .wdata (rp_wdata),
    .re (rp_re), .raddr (rp_raddr), .rdata (rp_rdata)
  );

  rcpr_ram #(.WIDTH(COL_AW), .DEPTH(MAX_COLS)) u_col_at (
    .clk (clk), .we (ca_we), .waddr (ca_waddr), .wdata (ca_wdata),
    .re (ca_re), .raddr (ca_raddr), .rdata (ca_rdata)
  );

  rcpr_ram #(.WIDTH(COL_AW), .DEPTH(MAX_COLS)) u_col_pos (
    .clk (clk), .we (cp_we), .waddr (cp_waddr), .wdata (cp_wdata),
    .re (cp_re), .raddr (cp_raddr), .rdata (cp_rdata)
  );

endmodule
